// File: rtl/imu_pkg.sv
// Shared types, constants and a helper function for the spin-lattice update block.
package imu_pkg;

	localparam int ADDR_W      = 12;
	localparam int DEPTH       = 4096;
	localparam int MAG_W       = 14;
	localparam int ENERGY_W    = 15;
	localparam int THR_W       = 16;
	localparam int THR_COUNT   = 4;
	localparam int THR_SEL_W   = 2;
	localparam int CFG_INDEX_W = 2;

	localparam int SIDE_DEFAULT       = 64;
	localparam int DIMENSIONS_DEFAULT = 2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_FIX,
		S_RD_UP,
		S_RD_DN,
		S_DECIDE
	} imu_state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_SITE,
		RD_NEIGH
	} rd_kind_t;

	// One coordinate step of the site index: the remaining higher digits and
	// whether the current digit sits on either edge of its dimension.
	typedef struct packed {
		logic [ADDR_W-1:0] quot;
		logic              at_low;
		logic              at_high;
	} digit_info_t;

	// side**n, evaluated at elaboration; n stays small, so 64 bits suffice.
	function automatic longint unsigned side_pow(input int unsigned side, input int unsigned n);
		longint unsigned p;
		p = 1;
		for (int unsigned i = 0; i < n; i++) begin
			p = p * side;
		end
		return p;
	endfunction

endpackage

// File: rtl/imu_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module imu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = imu_pkg::DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/imu_digit.sv
// Constant divider that splits one base-SIDE digit off the site index.
module imu_digit #(
	parameter int SIDE = imu_pkg::SIDE_DEFAULT
) (
	input  logic                       clk,
	input  logic                       mul_en,
	input  logic [imu_pkg::ADDR_W-1:0] rem,
	output imu_pkg::digit_info_t       info
);

	localparam int AW    = imu_pkg::ADDR_W;
	// Floor reciprocal: the quotient estimate is exact or one low for any AW-bit value.
	localparam int RECIP = imu_pkg::DEPTH / SIDE;

	localparam logic [AW-1:0] RECIP_C = AW'(RECIP);
	localparam logic [AW-1:0] SIDE_C  = AW'(SIDE);

	logic [2*AW-1:0] prod_q;
	logic [AW-1:0]   x_q;
	logic [AW-1:0]   q0;
	logic [2*AW-1:0] back_full;
	logic [AW-1:0]   r;
	logic            over;
	logic [AW-1:0]   digit;

	function automatic logic [2*AW-1:0] x_mul(input logic [AW-1:0] v);
		logic [2*AW-1:0] p;
		p = (2*AW)'(v) * (2*AW)'(RECIP_C);
		return p;
	endfunction

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= x_mul(rem);
			x_q    <= rem;
		end
	end

	always_comb begin
		q0        = prod_q[2*AW-1:AW];
		back_full = (2*AW)'(q0) * (2*AW)'(SIDE_C);
		r         = x_q - back_full[AW-1:0];
		over      = (r >= SIDE_C);
		digit     = over ? (r - SIDE_C) : r;
		info.quot    = over ? (q0 + AW'(1)) : q0;
		info.at_low  = (digit == '0);
		info.at_high = (digit == (SIDE_C - AW'(1)));
	end

endmodule

// File: rtl/imu_accept.sv
// Acceptance threshold registers and the random-draw comparison for an energy rise.
module imu_accept (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [imu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [imu_pkg::THR_W-1:0]       cfg_data,
	input  logic [imu_pkg::THR_SEL_W-1:0]   tsel,
	input  logic [imu_pkg::THR_W-1:0]       draw,
	output logic                            accept_rise
);

	logic [imu_pkg::THR_W-1:0] thr_q [imu_pkg::THR_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < imu_pkg::THR_COUNT; i++) begin
				thr_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			thr_q[cfg_index] <= cfg_data;
		end
	end

	// A zero threshold can never be beaten, so it refuses every rise.
	assign accept_rise = (draw < thr_q[tsel]);

endmodule

// File: rtl/ising_metropolis_update_unit.sv
// Top level: spin lattice memory, update sequencer, running totals and result register.
//
// Usage. Items enter on item_valid/item_stall with mode, site_index, spin_value and
// random_draw; a word is taken at a rising edge with item_valid high and item_stall low.
// Mode 0 loads a spin at a site, mode 1 runs one Metropolis step there. Every item gives
// one result word on result_valid/result_stall: flipped, site_spin and the running
// magnetisation and energy after the item. Thresholds are written through cfg_valid,
// cfg_index, cfg_data; cfg_ready is always high.
// Each item runs S_MUL and S_FIX per coordinate, then S_RD_UP, S_RD_DN and S_DECIDE;
// the next item is taken no earlier than that S_DECIDE step. The pace is set by the
// divider that splits off one coordinate at a time and by the single read port of
// the lattice memory, which reads the site and its 2*DIMENSIONS neighbours in turn.
// A finished result waits in the output register while the next item is already
// being worked on; when result_stall is held, the block completes that next item
// up to its final step and then holds item_stall high until the register frees.
// Reset: the lattice memory is cleared one site per cycle, all 4096 sites, with
// item_stall high; totals start at all spins down and thresholds at zero.
module ising_metropolis_update_unit #(
	parameter int SIDE       = imu_pkg::SIDE_DEFAULT,
	parameter int DIMENSIONS = imu_pkg::DIMENSIONS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   mode,
	input  logic [imu_pkg::ADDR_W-1:0]             site_index,
	input  logic                                   spin_value,
	input  logic [imu_pkg::THR_W-1:0]              random_draw,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic                                   flipped,
	output logic                                   site_spin,
	output logic signed [imu_pkg::MAG_W-1:0]       magnetisation,
	output logic signed [imu_pkg::ENERGY_W-1:0]    energy,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [imu_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [imu_pkg::THR_W-1:0]              cfg_data
);

	localparam int AW    = imu_pkg::ADDR_W;
	localparam int MW    = imu_pkg::MAG_W;
	localparam int EW    = imu_pkg::ENERGY_W;
	localparam int DW    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int SUM_W = $clog2(2 * DIMENSIONS + 1) + 1;

	localparam longint unsigned FULL_SITES = imu_pkg::side_pow(SIDE, DIMENSIONS);
	localparam int unsigned LIVE_SITES =
		(FULL_SITES > imu_pkg::DEPTH) ? imu_pkg::DEPTH : int'(FULL_SITES);

	localparam logic [AW:0]   LIVE_C   = (AW + 1)'(LIVE_SITES);
	localparam logic [AW:0]   DEPTH_C  = (AW + 1)'(imu_pkg::DEPTH);
	localparam logic [MW-1:0] MAG_RST  = MW'(0 - LIVE_SITES);
	localparam logic [EW-1:0] EN_RST   = EW'(0 - DIMENSIONS * LIVE_SITES);
	localparam logic [DW-1:0] DIM_LAST = DW'(DIMENSIONS - 1);

	// Per-dimension stride and wrap distance, with flags for whether they fit the memory.
	logic [AW-1:0] w_lo    [DIMENSIONS];
	logic          w_fit   [DIMENSIONS];
	logic [AW-1:0] wrap_lo [DIMENSIONS];
	logic          wrap_fit[DIMENSIONS];

	for (genvar g = 0; g < DIMENSIONS; g++) begin : g_dim
		localparam longint unsigned W    = imu_pkg::side_pow(SIDE, g);
		localparam longint unsigned WRAP = W * (SIDE - 1);
		assign w_lo[g]     = AW'(W);
		assign w_fit[g]    = (W < imu_pkg::DEPTH);
		assign wrap_lo[g]  = AW'(WRAP);
		assign wrap_fit[g] = (WRAP < imu_pkg::DEPTH);
	end

	imu_pkg::imu_state_t state_q, state_n;
	logic [DW-1:0]       dim_q;
	logic [AW-1:0]       clear_q;

	logic                mode_q;
	logic [AW-1:0]       idx_q;
	logic                spin_val_q;
	logic [imu_pkg::THR_W-1:0] draw_q;
	logic                in_range_q;
	logic [AW-1:0]       rem_q;

	logic [AW-1:0]       up_addr_q, dn_addr_q;
	logic                up_ok_q, dn_ok_q;
	logic [AW-1:0]       up_addr_n, dn_addr_n;
	logic                up_ok_n, dn_ok_n;
	logic [AW:0]         up_sum, dn_sum;

	imu_pkg::rd_kind_t   rd_kind_s1, rd_kind_n;
	logic                rd_ok_s1, rd_ok_n;
	logic                site_q;
	logic signed [SUM_W-1:0] sum_q, contrib, final_sum, ps, half;

	logic [MW-1:0]       mag_q, mag_n;
	logic [EW-1:0]       energy_q, energy_n;
	logic signed [EW-1:0] de;

	logic                out_valid_q, flipped_q, spin_out_q;
	logic [MW-1:0]       mag_out_q;
	logic [EW-1:0]       energy_out_q;

	logic                out_free, take_item, mul_en, fix_step, decide_go, clear_we;
	logic                rise, accept_rise, flip;
	logic [imu_pkg::THR_SEL_W-1:0] tsel;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [0:0]          ram_wdata, ram_rdata;

	imu_pkg::digit_info_t dinfo;

	imu_ram #(
		.WIDTH(1),
		.DEPTH(imu_pkg::DEPTH)
	) u_lattice (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	imu_digit #(
		.SIDE(SIDE)
	) u_digit (
		.clk   (clk),
		.mul_en(mul_en),
		.rem   (rem_q),
		.info  (dinfo)
	);

	imu_accept u_accept (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tsel       (tsel),
		.draw       (draw_q),
		.accept_rise(accept_rise)
	);

	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = !((state_q == imu_pkg::S_IDLE) ||
		((state_q == imu_pkg::S_DECIDE) && out_free));

	// Sequencer: the site read overlaps the first divide step; each neighbour pair is read
	// while the next coordinate is split off, the last pair in S_RD_UP and S_RD_DN.
	always_comb begin
		state_n   = state_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		rd_kind_n = imu_pkg::RD_NONE;
		rd_ok_n   = 1'b1;
		mul_en    = 1'b0;
		take_item = 1'b0;
		fix_step  = 1'b0;
		decide_go = 1'b0;
		clear_we  = 1'b0;
		unique case (state_q)
			imu_pkg::S_CLEAR: begin
				clear_we = 1'b1;
				if (clear_q == AW'(imu_pkg::DEPTH - 1)) begin
					state_n = imu_pkg::S_IDLE;
				end
			end
			imu_pkg::S_IDLE: begin
				if (item_valid) begin
					take_item = 1'b1;
					state_n   = imu_pkg::S_MUL;
				end
			end
			imu_pkg::S_MUL: begin
				mul_en  = 1'b1;
				ram_re  = 1'b1;
				state_n = imu_pkg::S_FIX;
				if (dim_q == '0) begin
					ram_raddr = idx_q;
					rd_kind_n = imu_pkg::RD_SITE;
				end else begin
					ram_raddr = up_addr_q;
					rd_kind_n = imu_pkg::RD_NEIGH;
					rd_ok_n   = up_ok_q;
				end
			end
			imu_pkg::S_FIX: begin
				fix_step = 1'b1;
				if (dim_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = dn_addr_q;
					rd_kind_n = imu_pkg::RD_NEIGH;
					rd_ok_n   = dn_ok_q;
				end
				state_n = (dim_q == DIM_LAST) ? imu_pkg::S_RD_UP : imu_pkg::S_MUL;
			end
			imu_pkg::S_RD_UP: begin
				ram_re    = 1'b1;
				ram_raddr = up_addr_q;
				rd_kind_n = imu_pkg::RD_NEIGH;
				rd_ok_n   = up_ok_q;
				state_n   = imu_pkg::S_RD_DN;
			end
			imu_pkg::S_RD_DN: begin
				ram_re    = 1'b1;
				ram_raddr = dn_addr_q;
				rd_kind_n = imu_pkg::RD_NEIGH;
				rd_ok_n   = dn_ok_q;
				state_n   = imu_pkg::S_DECIDE;
			end
			imu_pkg::S_DECIDE: begin
				if (out_free) begin
					decide_go = 1'b1;
					if (item_valid) begin
						take_item = 1'b1;
						state_n   = imu_pkg::S_MUL;
					end else begin
						state_n = imu_pkg::S_IDLE;
					end
				end
			end
			default: state_n = imu_pkg::S_IDLE;
		endcase
	end

	// Neighbour addresses for the coordinate just split off. A neighbour that falls
	// past the end of the memory is marked and counts as a down spin.
	always_comb begin
		up_sum = {1'b0, idx_q} + {1'b0, w_lo[dim_q]};
		dn_sum = {1'b0, idx_q} + {1'b0, wrap_lo[dim_q]};
		if (dinfo.at_high) begin
			up_addr_n = idx_q - wrap_lo[dim_q];
			up_ok_n   = 1'b1;
		end else begin
			up_addr_n = up_sum[AW-1:0];
			up_ok_n   = w_fit[dim_q] && (up_sum < DEPTH_C);
		end
		if (dinfo.at_low) begin
			dn_addr_n = dn_sum[AW-1:0];
			dn_ok_n   = wrap_fit[dim_q] && (dn_sum < DEPTH_C);
		end else begin
			dn_addr_n = idx_q - w_lo[dim_q];
			dn_ok_n   = 1'b1;
		end
	end

	// Energy change and the flip decision, taken as the last neighbour arrives.
	always_comb begin
		if ((rd_kind_s1 == imu_pkg::RD_NEIGH) && rd_ok_s1 && ram_rdata[0]) begin
			contrib = SUM_W'(1);
		end else if (rd_kind_s1 == imu_pkg::RD_NEIGH) begin
			contrib = -SUM_W'(1);
		end else begin
			contrib = '0;
		end
		final_sum = sum_q + contrib;
		ps        = site_q ? final_sum : -final_sum;
		half      = ps >>> 1;
		tsel      = imu_pkg::THR_SEL_W'(half - SUM_W'(1));
		rise      = (ps > 0);
		flip      = in_range_q &&
			(mode_q ? (!rise || accept_rise) : (spin_val_q != site_q));
		de        = EW'(ps) <<< 1;
		mag_n     = mag_q;
		energy_n  = energy_q;
		if (flip) begin
			mag_n    = site_q ? (mag_q - MW'(2)) : (mag_q + MW'(2));
			energy_n = energy_q + $unsigned(de);
		end
	end

	assign ram_we       = clear_we || (decide_go && flip);
	assign ram_waddr    = clear_we ? clear_q : idx_q;
	assign ram_wdata[0] = !clear_we && !site_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imu_pkg::S_CLEAR;
			dim_q       <= '0;
			clear_q     <= '0;
			rd_kind_s1  <= imu_pkg::RD_NONE;
			out_valid_q <= 1'b0;
			mag_q       <= MAG_RST;
			energy_q    <= EN_RST;
			sum_q       <= '0;
		end else begin
			state_q    <= state_n;
			rd_kind_s1 <= rd_kind_n;
			if (clear_we) begin
				clear_q <= clear_q + AW'(1);
			end
			if (take_item) begin
				dim_q <= '0;
				sum_q <= '0;
			end else begin
				sum_q <= final_sum;
				if (fix_step && (dim_q != DIM_LAST)) begin
					dim_q <= dim_q + DW'(1);
				end
			end
			if (decide_go) begin
				out_valid_q <= 1'b1;
				mag_q       <= mag_n;
				energy_q    <= energy_n;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ok_s1 <= rd_ok_n;
		if (take_item) begin
			mode_q     <= mode;
			idx_q      <= site_index;
			spin_val_q <= spin_value;
			draw_q     <= random_draw;
			in_range_q <= ({1'b0, site_index} < LIVE_C);
			rem_q      <= site_index;
		end else if (fix_step) begin
			rem_q <= dinfo.quot;
		end
		if (fix_step) begin
			up_addr_q <= up_addr_n;
			up_ok_q   <= up_ok_n;
			dn_addr_q <= dn_addr_n;
			dn_ok_q   <= dn_ok_n;
		end
		if (rd_kind_s1 == imu_pkg::RD_SITE) begin
			site_q <= ram_rdata[0];
		end
		if (decide_go) begin
			flipped_q    <= flip;
			spin_out_q   <= in_range_q && (site_q ^ flip);
			mag_out_q    <= mag_n;
			energy_out_q <= energy_n;
		end
	end

	assign result_valid  = out_valid_q;
	assign flipped       = flipped_q;
	assign site_spin     = spin_out_q;
	assign magnetisation = mag_out_q;
	assign energy        = energy_out_q;

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == imu_pkg::S_CLEAR || state_q == imu_pkg::S_DECIDE))
		else $error("lattice written outside clearing or decision");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == imu_pkg::S_DECIDE))
		else $error("result word appeared without a decision step");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imu_pkg::S_CLEAR) |-> item_stall)
		else $error("item taken while the lattice is being cleared");

	a_site_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_kind_s1 == imu_pkg::RD_SITE) |->
			$past(state_q == imu_pkg::S_MUL && dim_q == '0))
		else $error("site spin captured from a read that was not the site");

endmodule
